/* hdl/fcd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fcd_pkg;

	// frame store capacity, pixels per half of the ping-pong store
	localparam int MAX_PIXELS = 524288;

	localparam int PIX_W   = 8;
	localparam int THR_W   = 12;
	localparam int SUM_W   = 28;
	localparam int DSUM_W  = 27;
	localparam int CNT_W   = 20;
	localparam int POS_W   = $clog2(MAX_PIXELS + 1);
	localparam int ADDR_W  = $clog2(MAX_PIXELS);
	localparam int RAM_DEPTH = 2 ** (ADDR_W + 1);
	localparam int PROD_W  = THR_W + POS_W;
	localparam int CMP_W   = (SUM_W + 4 > PROD_W) ? SUM_W + 4 : PROD_W;

	// result item layout in m_tdata
	localparam int OUT_NEW   = 0;
	localparam int OUT_FIRST = 1;
	localparam int OUT_SUM   = 2;
	localparam int OUT_CNT   = OUT_SUM + DSUM_W;
	localparam int OUT_MISM  = OUT_CNT + CNT_W;
	localparam int OUT_LONG  = OUT_MISM + 1;
	localparam int OUT_W     = ((OUT_LONG + 1 + 7) / 8) * 8;

	localparam logic [THR_W-1:0] THRESHOLD_RST = THR_W'(128);

	typedef enum logic [0:0] {
		REG_THRESHOLD = 1'b0,
		REG_SKIP      = 1'b1
	} cfg_reg_t;

endpackage

`default_nettype wire

/* hdl/fcd_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module fcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr0,
	input  wire logic [$clog2(DEPTH)-1:0] raddr1,
	output logic      [WIDTH-1:0]         rdata0,
	output logic      [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

`default_nettype wire

/* hdl/frame_change_detector.sv */
`timescale 1ns / 1ps
`default_nettype none

// Frame change detector.
// Input stream: one gray pixel per item in s_tdata, s_tlast on the last pixel of a frame.
// Output stream: one result item per frame, issued for the item that carries s_tlast.
// The block sums |pixel - reference| over the pixels that the reference also holds
// and flags the frame as new when 16*diff_sum > change_threshold*pixel_count, when its
// length differs from the reference, or when no reference exists yet or skip_enable is 0.
// With skip_enable set, a new frame becomes the reference by flipping the store halves.
// Configuration: cfg_we/cfg_index/cfg_data, index 0 change_threshold, 1 skip_enable;
// write only while no frame is in flight.
// Throughput: one pixel per clock; an item enters every cycle the pipeline can advance.
// A frame's last pixel passes stage 1 and stage 2; its result is registered in m_tdata.
// The loop that sets the rate is the per-pixel reference read, absolute difference and
// running-sum add, closed against the dual-read frame store.
// Reset: counters, reference state and valids clear; the frame store needs no clearing,
// since only entries of the current reference frame are ever compared.
// Receiver stall: the result stays in the output register; pixels keep flowing until a
// further frame end reaches the last stage, then s_tready drops until m_tready returns.
module frame_change_detector (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [7:0]                    s_tdata,   // [7:0] pixel
	input  wire logic                          s_tlast,   // end_of_frame
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// [0] frame_is_new, [1] first_frame, [28:2] diff_sum, [48:29] pixel_count,
	// [49] length_mismatch, [50] frame_too_long, rest zero
	output logic [fcd_pkg::OUT_W-1:0]          m_tdata,
	input  wire logic                          cfg_we,
	input  wire logic [0:0]                    cfg_index,
	input  wire logic [fcd_pkg::THR_W-1:0]     cfg_data
);

	// configuration
	logic [fcd_pkg::THR_W-1:0] threshold_q;
	logic                      skip_q;

	// input-side frame tracking
	logic [fcd_pkg::POS_W-1:0] pos_q;
	logic                      ovf_q;
	logic                      s_accept;
	logic                      in_range;

	// reference state
	logic                      sel_q;
	logic                      have_ref_q;
	logic [fcd_pkg::POS_W-1:0] ref_len_q;
	logic [fcd_pkg::SUM_W-1:0] run_sum_q;

	// stage 1
	logic                      v_s1;
	logic [fcd_pkg::PIX_W-1:0] pix_s1;
	logic                      eof_s1;
	logic [fcd_pkg::POS_W-1:0] pos_s1;
	logic                      store_s1;
	logic [fcd_pkg::POS_W-1:0] cnt_s1;
	logic                      long_s1;

	// stage 2
	logic                       v_s2;
	logic [fcd_pkg::PIX_W-1:0]  pix_s2;
	logic                       eof_s2;
	logic [fcd_pkg::POS_W-1:0]  pos_s2;
	logic                       store_s2;
	logic [fcd_pkg::POS_W-1:0]  cnt_s2;
	logic                       long_s2;
	logic [fcd_pkg::PROD_W-1:0] prod_s2;

	logic out_free, s1_go, s2_go, s2_emit;

	// frame store
	logic [fcd_pkg::ADDR_W-1:0] rd_pos;
	logic                       ram_we;
	logic [fcd_pkg::ADDR_W:0]   ram_waddr;
	logic [fcd_pkg::PIX_W-1:0]  rdata0, rdata1;
	logic [1:0]                 byp_hit_q;
	logic [fcd_pkg::PIX_W-1:0]  byp_data_q;

	// stage 2 datapath
	logic [fcd_pkg::PIX_W-1:0] ref_pix;
	logic                      use_ref;
	logic [fcd_pkg::PIX_W-1:0] abs_diff;
	logic [fcd_pkg::SUM_W-1:0] sum_acc;
	logic [fcd_pkg::CMP_W-1:0] cmp_lhs, cmp_rhs;
	logic                      first, mism, is_new, take_ref;
	logic [fcd_pkg::SUM_W-1:0] sum_out;

	// ---------------- handshake ----------------
	assign out_free = !m_tvalid || m_tready;
	assign s2_go    = v_s2 && (!eof_s2 || out_free);
	assign s2_emit  = s2_go && eof_s2;
	assign s1_go    = v_s1 && (!v_s2 || s2_go);
	assign s_tready = !v_s1 || s1_go;
	assign s_accept = s_tvalid && s_tready;

	assign in_range = pos_q < fcd_pkg::POS_W'(fcd_pkg::MAX_PIXELS);

	// ---------------- frame store ----------------
	// read both halves at the position of the item that sits in stage 2 next cycle,
	// the half is picked once the previous frame's decision is known
	assign rd_pos    = s1_go ? pos_s1[fcd_pkg::ADDR_W-1:0] : pos_s2[fcd_pkg::ADDR_W-1:0];
	assign ram_we    = s2_go && store_s2;
	assign ram_waddr = {!sel_q, pos_s2[fcd_pkg::ADDR_W-1:0]};

	fcd_ram #(
		.WIDTH(fcd_pkg::PIX_W),
		.DEPTH(fcd_pkg::RAM_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (pix_s2),
		.raddr0({1'b0, rd_pos}),
		.raddr1({1'b1, rd_pos}),
		.rdata0(rdata0),
		.rdata1(rdata1)
	);

	// ---------------- stage 2 datapath ----------------
	always_comb begin
		if (byp_hit_q[sel_q]) begin
			ref_pix = byp_data_q;
		end else begin
			ref_pix = sel_q ? rdata1 : rdata0;
		end
		use_ref  = have_ref_q && store_s2 && (pos_s2 < ref_len_q);
		abs_diff = (pix_s2 > ref_pix) ? pix_s2 - ref_pix : ref_pix - pix_s2;
		sum_acc  = run_sum_q + (use_ref ? fcd_pkg::SUM_W'(abs_diff) : '0);
		cmp_lhs  = fcd_pkg::CMP_W'({sum_acc, 4'b0000});
		cmp_rhs  = fcd_pkg::CMP_W'(prod_s2);
		first    = !have_ref_q;
		if (!skip_q || first) begin
			is_new  = 1'b1;
			sum_out = '0;
			mism    = 1'b0;
		end else begin
			sum_out = sum_acc;
			mism    = cnt_s2 != ref_len_q;
			is_new  = mism || (cmp_lhs > cmp_rhs);
		end
		take_ref = skip_q && is_new;
	end

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= fcd_pkg::THRESHOLD_RST;
			skip_q      <= 1'b1;
			pos_q       <= '0;
			ovf_q       <= 1'b0;
			sel_q       <= 1'b0;
			have_ref_q  <= 1'b0;
			ref_len_q   <= '0;
			run_sum_q   <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			m_tvalid    <= 1'b0;
			byp_hit_q   <= '0;
		end else begin
			if (cfg_we) begin
				unique case (fcd_pkg::cfg_reg_t'(cfg_index))
					fcd_pkg::REG_THRESHOLD: threshold_q <= cfg_data;
					fcd_pkg::REG_SKIP:      skip_q      <= cfg_data[0];
					default: ;
				endcase
			end

			if (s_accept) begin
				if (s_tlast) begin
					pos_q <= '0;
					ovf_q <= 1'b0;
				end else if (in_range) begin
					pos_q <= pos_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end

			if (s_accept) begin
				v_s1 <= 1'b1;
			end else if (s1_go) begin
				v_s1 <= 1'b0;
			end

			if (s1_go) begin
				v_s2 <= 1'b1;
			end else if (s2_go) begin
				v_s2 <= 1'b0;
			end

			if (s2_go) begin
				run_sum_q <= eof_s2 ? '0 : sum_acc;
			end
			if (s2_emit && take_ref) begin
				sel_q      <= !sel_q;
				ref_len_q  <= cnt_s2;
				have_ref_q <= 1'b1;
			end

			if (s2_emit) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end

			// write and read of the same entry in the same cycle: forward the written pixel
			byp_hit_q <= {ram_we && (ram_waddr == {1'b1, rd_pos}),
				ram_we && (ram_waddr == {1'b0, rd_pos})};
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= pix_s2;
		if (s_accept) begin
			pix_s1   <= s_tdata;
			eof_s1   <= s_tlast;
			pos_s1   <= pos_q;
			store_s1 <= in_range;
			cnt_s1   <= pos_q + fcd_pkg::POS_W'(in_range);
			long_s1  <= ovf_q || !in_range;
		end
		if (s1_go) begin
			pix_s2   <= pix_s1;
			eof_s2   <= eof_s1;
			pos_s2   <= pos_s1;
			store_s2 <= store_s1;
			cnt_s2   <= cnt_s1;
			long_s2  <= long_s1;
			prod_s2  <= fcd_pkg::PROD_W'(threshold_q) * fcd_pkg::PROD_W'(cnt_s1);
		end
		if (s2_emit) begin
			m_tdata <= fcd_pkg::OUT_W'({long_s2, mism, cnt_s2[fcd_pkg::CNT_W-1:0],
				sum_out[fcd_pkg::DSUM_W-1:0], first, is_new});
		end
	end

	// ---------------- assertions ----------------
	a_first_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[fcd_pkg::OUT_FIRST] |->
			m_tdata[fcd_pkg::OUT_NEW] && !m_tdata[fcd_pkg::OUT_MISM] &&
			(m_tdata[fcd_pkg::OUT_SUM +: fcd_pkg::DSUM_W] == '0))
		else $error("first frame result carries a difference or mismatch");

	a_mism_new: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[fcd_pkg::OUT_MISM] |-> m_tdata[fcd_pkg::OUT_NEW])
		else $error("length mismatch reported without a new frame");

	a_ref_kept: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(have_ref_q))
		else $error("reference lost without reset");

	a_ref_len: assert property (@(posedge clk) disable iff (!arst_n)
		have_ref_q |-> (ref_len_q != '0) &&
			(ref_len_q <= fcd_pkg::POS_W'(fcd_pkg::MAX_PIXELS)))
		else $error("reference length out of range");

	a_flip_on_new: assert property (@(posedge clk) disable iff (!arst_n)
		s2_emit && !is_new |=> $stable(sel_q) && $stable(ref_len_q))
		else $error("reference swapped on an unchanged frame");

endmodule

`default_nettype wire

/* test/tb_frame_change_detector.sv */
`timescale 1ns / 1ps

module tb_frame_change_detector;

	localparam int STALL_CYCLES = 150;
	localparam int RANDOM_PIXELS = 2000;
	localparam int MAX_PRINTED = 40;

	typedef struct packed {
		logic                       is_new;
		logic                       first;
		logic [fcd_pkg::DSUM_W-1:0] dsum;
		logic [fcd_pkg::CNT_W-1:0]  cnt;
		logic                       mism;
		logic                       too_long;
	} frame_verdict_t;

	logic                         clk;
	logic                         arst_n;
	logic                         s_tvalid;
	logic                         s_tready;
	logic [7:0]                   s_tdata;
	logic                         s_tlast;
	logic                         m_tvalid;
	logic                         m_tready;
	logic [fcd_pkg::OUT_W-1:0]    m_tdata;
	logic                         cfg_we;
	logic [0:0]                   cfg_index;
	logic [fcd_pkg::THR_W-1:0]    cfg_data;

	frame_change_detector dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor state: ping-pong picture store and per-frame accumulators
	bit [7:0]                    frame_mem [0:2*fcd_pkg::MAX_PIXELS-1];
	bit                          ref_half;
	bit                          ref_valid;
	int unsigned                 pix_pos;
	bit [fcd_pkg::SUM_W-1:0]     sad_acc;
	int unsigned                 ref_len;
	bit                          spill;
	bit [fcd_pkg::THR_W-1:0]     thr_q;
	bit                          cmp_en;

	frame_verdict_t   verdict_q [$];

	int unsigned      errors;
	int unsigned      frames_checked;
	int unsigned      pixels_sent;
	bit               tx_idle_en;
	bit               rx_idle_en;
	int unsigned      rx_hold_len;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin : watchdog
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

	task automatic flag_error(input string what, input longint got, input longint want);
		if (errors < MAX_PRINTED)
			$display("ERROR result %0d %s: got %0d, expected %0d",
				frames_checked, what, got, want);
		errors++;
	endtask

	function automatic void predict_pixel(input bit [7:0] px, input bit eof);
		int unsigned    work_base;
		int unsigned    ref_base;
		int unsigned    r;
		int unsigned    d;
		longint         lhs;
		longint         rhs;
		frame_verdict_t v;
		work_base = ref_half ? 0 : fcd_pkg::MAX_PIXELS;
		ref_base = ref_half ? fcd_pkg::MAX_PIXELS : 0;
		if (pix_pos < fcd_pkg::MAX_PIXELS) begin
			frame_mem[work_base + pix_pos] = px;
			if (ref_valid && pix_pos < ref_len) begin
				r = frame_mem[ref_base + pix_pos];
				d = (px > r) ? px - r : r - px;
				sad_acc = sad_acc + d[fcd_pkg::SUM_W-1:0];
			end
			pix_pos++;
		end else begin
			spill = 1'b1;
		end
		if (eof) begin
			v.cnt = pix_pos[fcd_pkg::CNT_W-1:0];
			v.too_long = spill;
			v.first = !ref_valid;
			if (!cmp_en || !ref_valid) begin
				v.is_new = 1'b1;
				v.dsum = '0;
				v.mism = 1'b0;
			end else begin
				v.dsum = sad_acc[fcd_pkg::DSUM_W-1:0];
				v.mism = (pix_pos != ref_len);
				lhs = 16 * longint'(sad_acc);
				rhs = longint'(thr_q) * longint'(pix_pos);
				v.is_new = v.mism || (lhs > rhs);
			end
			if (cmp_en && v.is_new) begin
				ref_half = !ref_half;
				ref_len = pix_pos;
				ref_valid = 1'b1;
			end
			verdict_q.push_back(v);
			pix_pos = 0;
			sad_acc = '0;
			spill = 1'b0;
		end
	endfunction

	task automatic send_pixel(input bit [7:0] px, input bit eof);
		int unsigned gap;
		gap = tx_idle_en ? $urandom_range(0, 5) : 0;
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= px;
		s_tlast <= eof;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_pixel(px, eof);
		pixels_sent++;
	endtask

	// drop valid, let every pending result come out, then let the pipe settle
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input fcd_pkg::cfg_reg_t idx,
		input bit [fcd_pkg::THR_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			fcd_pkg::REG_THRESHOLD: thr_q = val;
			fcd_pkg::REG_SKIP:      cmp_en = val[0];
			default: ;
		endcase
	endtask

	// frame content near the reference, or of odd length, or plain noise
	task automatic send_random_frame();
		int unsigned kind;
		int unsigned len;
		int unsigned spread;
		int unsigned ref_base;
		int unsigned i;
		int          px;
		kind = $urandom_range(0, 9);
		ref_base = ref_half ? fcd_pkg::MAX_PIXELS : 0;
		if (ref_valid && ref_len <= 32 && kind < 6)
			len = ref_len;
		else if (ref_valid && ref_len <= 32 && kind < 8)
			len = ($urandom_range(0, 1) || ref_len == 1) ? ref_len + 1 : ref_len - 1;
		else
			len = $urandom_range(1, 16);
		spread = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 12);
		for (i = 0; i < len; i++) begin
			if (ref_valid && i < ref_len && kind < 8) begin
				px = int'(frame_mem[ref_base + i]) + int'($urandom_range(0, 2 * spread))
					- int'(spread);
				if (px < 0) px = 0;
				if (px > 255) px = 255;
			end else begin
				px = $urandom_range(0, 255);
			end
			send_pixel(8'(px), i == len - 1);
		end
	endtask

	task automatic test_reset_defaults();
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd255, 1'b1);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd0, 1'b1);
		// identical frame, no change expected
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd0, 1'b1);
		// shorter frames
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd1, 1'b1);
		send_pixel(8'd200, 1'b1);
		wait_idle();
	endtask

	task automatic test_threshold_extremes();
		write_reg(fcd_pkg::REG_THRESHOLD, '0);
		send_pixel(8'd200, 1'b1);
		send_pixel(8'd201, 1'b1);
		wait_idle();
		// largest threshold: a mean can never exceed it
		write_reg(fcd_pkg::REG_THRESHOLD, '1);
		send_pixel(8'd0, 1'b1);
		send_pixel(8'd255, 1'b1);
		wait_idle();
	endtask

	task automatic test_compare_disabled();
		write_reg(fcd_pkg::REG_SKIP, 12'd0);
		send_pixel(8'd7, 1'b1);
		wait_idle();
		write_reg(fcd_pkg::REG_SKIP, 12'd1);
		write_reg(fcd_pkg::REG_THRESHOLD, fcd_pkg::THRESHOLD_RST);
		// reference must still be the frame from before
		send_pixel(8'd201, 1'b1);
		wait_idle();
	endtask

	task automatic test_random_traffic();
		int unsigned phase;
		int unsigned goal;
		int unsigned f;
		bit [fcd_pkg::THR_W-1:0] thr;
		phase = 0;
		goal = pixels_sent + RANDOM_PIXELS;
		while (pixels_sent < goal) begin
			case (phase % 6)
				0:       thr = '0;
				1:       thr = '1;
				default: thr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
					: $urandom_range(0, 320);
			endcase
			write_reg(fcd_pkg::REG_THRESHOLD, thr);
			write_reg(fcd_pkg::REG_SKIP, (phase % 4 == 3) ? 12'd0 : 12'd1);
			tx_idle_en = (phase % 5 != 4);
			rx_idle_en = (phase % 5 != 4);
			for (f = 0; f < 30; f++)
				send_random_frame();
			wait_idle();
			phase++;
		end
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		write_reg(fcd_pkg::REG_SKIP, 12'd1);
	endtask

	// receiver holds off while the sender keeps offering short frames
	task automatic test_output_stall();
		int unsigned f;
		tx_idle_en = 1'b0;
		rx_hold_len = STALL_CYCLES;
		for (f = 0; f < 40; f++) begin
			send_pixel(8'($urandom_range(0, 255)), 1'b0);
			send_pixel(8'($urandom_range(0, 255)), 1'b0);
			send_pixel(8'($urandom_range(0, 255)), 1'b1);
		end
		wait_idle();
		tx_idle_en = 1'b1;
	endtask

	initial begin : result_sink
		int unsigned stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (rx_hold_len != 0) begin
				stall = rx_hold_len;
				rx_hold_len = 0;
			end else begin
				stall = rx_idle_en ? $urandom_range(0, 5) : 0;
			end
			repeat (stall) begin
				@(negedge clk);
				m_tready <= 1'b0;
			end
			@(negedge clk);
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	initial begin : result_check
		frame_verdict_t            want;
		logic [fcd_pkg::OUT_W-1:0] got;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got = m_tdata;
				if (verdict_q.size() == 0) begin
					flag_error("result with no frame end pending",
						got[fcd_pkg::OUT_CNT +: fcd_pkg::CNT_W], 0);
				end else begin
					want = verdict_q.pop_front();
					if (got[fcd_pkg::OUT_NEW] !== want.is_new)
						flag_error("frame_is_new", got[fcd_pkg::OUT_NEW], want.is_new);
					if (got[fcd_pkg::OUT_FIRST] !== want.first)
						flag_error("first_frame", got[fcd_pkg::OUT_FIRST], want.first);
					if (got[fcd_pkg::OUT_SUM +: fcd_pkg::DSUM_W] !== want.dsum)
						flag_error("diff_sum", got[fcd_pkg::OUT_SUM +: fcd_pkg::DSUM_W],
							want.dsum);
					if (got[fcd_pkg::OUT_CNT +: fcd_pkg::CNT_W] !== want.cnt)
						flag_error("pixel_count", got[fcd_pkg::OUT_CNT +: fcd_pkg::CNT_W],
							want.cnt);
					if (got[fcd_pkg::OUT_MISM] !== want.mism)
						flag_error("length_mismatch", got[fcd_pkg::OUT_MISM], want.mism);
					if (got[fcd_pkg::OUT_LONG] !== want.too_long)
						flag_error("frame_too_long", got[fcd_pkg::OUT_LONG], want.too_long);
					if (got[fcd_pkg::OUT_W-1:fcd_pkg::OUT_LONG+1] !== '0)
						flag_error("padding bits", got[fcd_pkg::OUT_W-1:fcd_pkg::OUT_LONG+1],
							0);
				end
				frames_checked++;
			end
		end
	end

	initial begin : run
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		cfg_we = 1'b0;
		cfg_index = fcd_pkg::REG_THRESHOLD;
		cfg_data = '0;
		ref_half = 1'b0;
		ref_valid = 1'b0;
		pix_pos = 0;
		sad_acc = '0;
		ref_len = 0;
		spill = 1'b0;
		thr_q = fcd_pkg::THRESHOLD_RST;
		cmp_en = 1'b1;
		errors = 0;
		frames_checked = 0;
		pixels_sent = 0;
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		rx_hold_len = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_threshold_extremes();
		test_compare_disabled();
		test_random_traffic();
		test_output_stall();

		wait_idle();
		repeat (8) @(posedge clk);
		if (verdict_q.size() != 0)
			flag_error("frames never reported", 0, verdict_q.size());

		$display("Sent %0d pixels, checked %0d frame results of short and uneven lengths.",
			pixels_sent, frames_checked);
		$display("Threshold swept 0 to 4095, comparison on and off, output held off %0d cycles.",
			STALL_CYCLES);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
